// ===== src/point_to_line_distance_3d_core_defines.svh =====
// Assertion macros used by the RTL.
// Each expects clk and arst_n in scope.
`ifndef POINT_TO_LINE_DISTANCE_3D_CORE_DEFINES_SVH
`define POINT_TO_LINE_DISTANCE_3D_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define PTLD_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define PTLD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/ptld_pkg.sv =====
`default_nettype none
package ptld_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int DIST_BITS      = 25;
	localparam int OUT_DATA_W     = ((DIST_BITS + 7) / 8) * 8;
	localparam int CFG_IDX_W      = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANCHOR_X = 3'd0,
		REG_ANCHOR_Y = 3'd1,
		REG_ANCHOR_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5
	} cfg_reg_t;
endpackage
`default_nettype wire

// ===== src/ptld_front.sv =====
`default_nettype none
module ptld_front #(
	parameter int CW  = 16,
	parameter int FRAC = 8,
	parameter int DDW = 2 * CW + 2,
	parameter int AW  = 88
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic signed [CW-1:0] qx,
	input  wire logic signed [CW-1:0] qy,
	input  wire logic signed [CW-1:0] qz,
	input  wire logic signed [CW-1:0] ax,
	input  wire logic signed [CW-1:0] ay,
	input  wire logic signed [CW-1:0] az,
	input  wire logic signed [CW-1:0] dx,
	input  wire logic signed [CW-1:0] dy,
	input  wire logic signed [CW-1:0] dz,
	output logic                      out_valid,
	output logic [AW-1:0]             out_rem,
	output logic [DDW-1:0]            out_dd,
	output logic                      out_degen
);
	localparam int VW  = CW + 1;
	localparam int PW  = VW + CW;
	localparam int XW  = PW + 1;
	localparam int SQW = 2 * XW;
	localparam int CCW = SQW + 2;

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [VW-1:0]    vx_s1, vy_s1, vz_s1;
	logic signed [PW-1:0]    p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	logic signed [2*CW-1:0]  ddx_s2, ddy_s2, ddz_s2;
	logic signed [XW-1:0]    cx_s3, cy_s3, cz_s3;
	logic signed [DDW-1:0]   dd_s3;
	logic [SQW-1:0]          sqx_s4, sqy_s4, sqz_s4;
	logic [DDW-1:0]          dd_s4, dd_s5;
	logic [AW-1:0]           rem_s5;
	logic                    degen_s5;
	logic [CCW-1:0]          cc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign cc = CCW'(sqx_s4) + CCW'(sqy_s4) + CCW'(sqz_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			// offset from the anchor
			vx_s1 <= VW'(qx) - VW'(ax);
			vy_s1 <= VW'(qy) - VW'(ay);
			vz_s1 <= VW'(qz) - VW'(az);
			// cross product terms and direction squares
			p1_s2  <= PW'(vy_s1) * PW'(dz);
			p2_s2  <= PW'(vz_s1) * PW'(dy);
			p3_s2  <= PW'(vz_s1) * PW'(dx);
			p4_s2  <= PW'(vx_s1) * PW'(dz);
			p5_s2  <= PW'(vx_s1) * PW'(dy);
			p6_s2  <= PW'(vy_s1) * PW'(dx);
			ddx_s2 <= (2*CW)'(dx) * (2*CW)'(dx);
			ddy_s2 <= (2*CW)'(dy) * (2*CW)'(dy);
			ddz_s2 <= (2*CW)'(dz) * (2*CW)'(dz);
			cx_s3  <= XW'(p1_s2) - XW'(p2_s2);
			cy_s3  <= XW'(p3_s2) - XW'(p4_s2);
			cz_s3  <= XW'(p5_s2) - XW'(p6_s2);
			dd_s3  <= DDW'(ddx_s2) + DDW'(ddy_s2) + DDW'(ddz_s2);
			sqx_s4 <= SQW'(cx_s3) * SQW'(cx_s3);
			sqy_s4 <= SQW'(cy_s3) * SQW'(cy_s3);
			sqz_s4 <= SQW'(cz_s3) * SQW'(cz_s3);
			dd_s4  <= dd_s3;
			// scale by the fraction bits twice over: the root halves it
			rem_s5   <= AW'(cc) << (2 * FRAC);
			dd_s5    <= dd_s4;
			degen_s5 <= (dd_s4 == '0);
		end
	end

	assign out_valid = vld_s5;
	assign out_rem   = rem_s5;
	assign out_dd    = dd_s5;
	assign out_degen = degen_s5;
endmodule
`default_nettype wire

// ===== src/ptld_root_stage.sv =====
`default_nettype none
module ptld_root_stage #(
	parameter int DDW = 34,
	parameter int RW  = 25,
	parameter int AW  = 88,
	parameter int BIT = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic [RW-1:0]       in_root,
	input  wire logic [DDW+RW-1:0]   in_q,
	input  wire logic [AW-1:0]       in_rem,
	input  wire logic [DDW-1:0]      in_dd,
	input  wire logic                in_degen,
	output logic                     out_valid,
	output logic [RW-1:0]            out_root,
	output logic [DDW+RW-1:0]        out_q,
	output logic [AW-1:0]            out_rem,
	output logic [DDW-1:0]           out_dd,
	output logic                     out_degen
);
	localparam int QW = DDW + RW;

	logic            vld_s1;
	logic [RW-1:0]   root_s1;
	logic [QW-1:0]   q_s1;
	logic [AW-1:0]   rem_s1;
	logic [DDW-1:0]  dd_s1;
	logic            degen_s1;
	logic [AW-1:0]   trial;
	logic            take;

	// growth of root^2*dd when this bit is set: 2*bit*dd*root + bit^2*dd
	assign trial = (AW'(in_q) << (BIT + 1)) + (AW'(in_dd) << (2 * BIT));
	assign take  = (trial <= in_rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_s1  <= take ? (in_root | (RW'(1) << BIT)) : in_root;
			q_s1     <= take ? (in_q + (QW'(in_dd) << BIT)) : in_q;
			rem_s1   <= take ? (in_rem - trial) : in_rem;
			dd_s1    <= in_dd;
			degen_s1 <= in_degen;
		end
	end

	assign out_valid = vld_s1;
	assign out_root  = root_s1;
	assign out_q     = q_s1;
	assign out_rem   = rem_s1;
	assign out_dd    = dd_s1;
	assign out_degen = degen_s1;
endmodule
`default_nettype wire

// ===== src/point_to_line_distance_3d_core.sv =====
// Distance from streamed 3D points to a fixed line.
// Configuration: write anchor (index 0..2) and direction (index 3..5) through
// cfg_we/cfg_index/cfg_wdata while no transaction is in flight; other
// indexes are dropped.
// Input: one point per transaction on s_tvalid/s_tready/s_tdata.
// Output: floor(2^FRAC_BITS * distance) on m_tdata, degenerate flag on m_tuser.
// Throughput: one transaction per cycle, sustained while the sink is ready.
// Pipeline: five arithmetic stages (offset, products, cross, squares, sums),
// then one stage per result bit of the shift-and-subtract square root.
// Stall: when m_tready is low with a result pending the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
// Reset: clears valid bits and zeroes all six configuration registers.
// A zero direction reports distance 0 with the degenerate flag set.
`default_nettype none
`include "point_to_line_distance_3d_core_defines.svh"
module point_to_line_distance_3d_core
	import ptld_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]                     cfg_index,
	input  wire logic [COORD_BITS-1:0]                    cfg_wdata,
	input  wire logic                                     s_tvalid,
	output logic                                          s_tready,
	// query_x, query_y, query_z from bit 0 up, zero padded to bytes
	input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]        s_tdata,
	output logic                                          m_tvalid,
	input  wire logic                                     m_tready,
	// distance from bit 0 up, zero padded to bytes
	output logic [OUT_DATA_W-1:0]                         m_tdata,
	// degenerate
	output logic [0:0]                                    m_tuser
);
	localparam int CW  = COORD_BITS;
	localparam int RW  = CW + 1 + FRAC_BITS;
	localparam int DDW = 2 * CW + 2;
	localparam int TW  = 4 * CW + 6 + 2 * FRAC_BITS;
	localparam int AW  = ((TW > DDW + 2 * RW) ? TW : DDW + 2 * RW) + 2;
	localparam int QW  = DDW + RW;

	logic signed [CW-1:0] anchor_x_q, anchor_y_q, anchor_z_q;
	logic signed [CW-1:0] dir_x_q, dir_y_q, dir_z_q;
	logic                 en;

	logic            vld_p   [0:RW];
	logic [RW-1:0]   root_p  [0:RW];
	logic [QW-1:0]   q_p     [0:RW];
	logic [AW-1:0]   rem_p   [0:RW];
	logic [DDW-1:0]  dd_p    [0:RW];
	logic            degen_p [0:RW];
	logic [RW-1:0]   dist_val;

	// Configuration writes: one register per write, unknown indexes dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_x_q <= '0;
			anchor_y_q <= '0;
			anchor_z_q <= '0;
			dir_x_q    <= '0;
			dir_y_q    <= '0;
			dir_z_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANCHOR_X: anchor_x_q <= cfg_wdata;
				REG_ANCHOR_Y: anchor_y_q <= cfg_wdata;
				REG_ANCHOR_Z: anchor_z_q <= cfg_wdata;
				REG_DIR_X:    dir_x_q    <= cfg_wdata;
				REG_DIR_Y:    dir_y_q    <= cfg_wdata;
				REG_DIR_Z:    dir_z_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Advance every stage unless the result at the end is held by the sink.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	ptld_front #(
		.CW  (CW),
		.FRAC(FRAC_BITS),
		.DDW (DDW),
		.AW  (AW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.qx       (s_tdata[CW-1:0]),
		.qy       (s_tdata[2*CW-1:CW]),
		.qz       (s_tdata[3*CW-1:2*CW]),
		.ax       (anchor_x_q),
		.ay       (anchor_y_q),
		.az       (anchor_z_q),
		.dx       (dir_x_q),
		.dy       (dir_y_q),
		.dz       (dir_z_q),
		.out_valid(vld_p[0]),
		.out_rem  (rem_p[0]),
		.out_dd   (dd_p[0]),
		.out_degen(degen_p[0])
	);

	assign root_p[0] = '0;
	assign q_p[0]    = '0;

	// One stage per root bit, most significant first.
	for (genvar k = 0; k < RW; k++) begin : g_root
		ptld_root_stage #(
			.DDW(DDW),
			.RW (RW),
			.AW (AW),
			.BIT(RW - 1 - k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (vld_p[k]),
			.in_root  (root_p[k]),
			.in_q     (q_p[k]),
			.in_rem   (rem_p[k]),
			.in_dd    (dd_p[k]),
			.in_degen (degen_p[k]),
			.out_valid(vld_p[k+1]),
			.out_root (root_p[k+1]),
			.out_q    (q_p[k+1]),
			.out_rem  (rem_p[k+1]),
			.out_dd   (dd_p[k+1]),
			.out_degen(degen_p[k+1])
		);
	end

	// A zero direction lets every bit through; force the distance to zero.
	assign dist_val   = degen_p[RW] ? '0 : root_p[RW];
	assign m_tvalid   = vld_p[RW];
	assign m_tdata    = OUT_DATA_W'(DIST_BITS'(dist_val));
	assign m_tuser[0] = degen_p[RW];

	`PTLD_ASSERT_NOW(a_ready_only_stalls_on_sink, !s_tready, m_tvalid && !m_tready)
	`PTLD_ASSERT_NOW(a_degen_needs_zero_dir, m_tvalid && m_tuser[0],
		dir_x_q == '0 && dir_y_q == '0 && dir_z_q == '0)
	`PTLD_ASSERT_NOW(a_degen_zero_dist, m_tvalid && m_tuser[0], m_tdata == '0)
endmodule
`default_nettype wire

// ===== test/point_to_line_distance_3d_core_tb.sv =====
`default_nettype none
module point_to_line_distance_3d_core_tb
	import ptld_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = COORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int IN_W = ((3 * CB + 7) / 8) * 8;
	localparam int LATENCY = 5 + CB + 1 + FB;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_POINTS = 2000;
	localparam int N_DIRECTED = 12;

	typedef struct packed {
		logic [24:0] distance;
		logic        degenerate;
	} dist_result_t;

	typedef struct {
		logic [CB-1:0] qx, qy, qz;
		logic          has_expect;   // distance typed in by hand
		dist_result_t  known;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CB-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;

	// Line held by the predictor: anchor then direction, indexed like the registers
	logic signed [CB-1:0] line_reg [6];
	dist_result_t pending_dist [$];
	int errors = 0;
	int cycles = 0;
	int stall_left = 0;
	bit quiet_tail = 1'b0;
	bit stim_done = 1'b0;

	always #10 clk = ~clk;

	point_to_line_distance_3d_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Exact distance: largest r with r^2*|D|^2 <= |VxD|^2 * 2^(2*FB)
	function automatic dist_result_t line_distance(logic [CB-1:0] px, logic [CB-1:0] py,
			logic [CB-1:0] pz);
		logic signed [63:0] vx, vy, vz, dx, dy, dz, cx, cy, cz;
		logic [255:0] dd, target, cand, root;
		dist_result_t r;
		dx = line_reg[REG_DIR_X];
		dy = line_reg[REG_DIR_Y];
		dz = line_reg[REG_DIR_Z];
		vx = $signed(px) - line_reg[REG_ANCHOR_X];
		vy = $signed(py) - line_reg[REG_ANCHOR_Y];
		vz = $signed(pz) - line_reg[REG_ANCHOR_Z];
		dd = dx * dx + dy * dy + dz * dz;
		r.distance = '0;
		r.degenerate = (dd == 0);
		if (dd == 0)
			return r;
		cx = vy * dz - dy * vz;
		cy = vz * dx - dz * vx;
		cz = vx * dy - dx * vy;
		target = (256'(cx) * 256'(cx) + 256'(cy) * 256'(cy) + 256'(cz) * 256'(cz))
			<< (2 * FB);
		root = '0;
		for (int b = 55; b >= 0; b--) begin
			cand = root | (256'd1 << b);
			if (cand * cand * dd <= target)
				root = cand;
		end
		r.distance = root[24:0];
		return r;
	endfunction

	// Write one register at a falling edge, mirror it in the predictor
	task automatic write_line_reg(cfg_reg_t idx, logic [CB-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		line_reg[idx] = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_line(logic [CB-1:0] ax, ay, az, ddx, ddy, ddz);
		write_line_reg(REG_ANCHOR_X, ax);
		write_line_reg(REG_ANCHOR_Y, ay);
		write_line_reg(REG_ANCHOR_Z, az);
		write_line_reg(REG_DIR_X, ddx);
		write_line_reg(REG_DIR_Y, ddy);
		write_line_reg(REG_DIR_Z, ddz);
	endtask

	// Drop to idle: wait for every result, then wait longer than the pipeline depth
	task automatic drain_results();
		while (pending_dist.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Offer one point, at times after an idle gap; else hold tvalid across back-to-back transactions
	task automatic send_point(logic [CB-1:0] px, py, pz);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({pz, py, px});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_dist.push_back(line_distance(px, py, pz));
		@(negedge clk);
	endtask

	task automatic send_random(int n, bit near_line);
		logic [CB-1:0] px, py, pz;
		int t;
		for (int i = 0; i < n; i++) begin
			// Points close to the line keep the distance small and exercise low bits
			if (near_line) begin
				t = $urandom_range(0, 7);
				px = CB'(line_reg[REG_ANCHOR_X] + line_reg[REG_DIR_X] * t
					+ $urandom_range(0, 6) - 3);
				py = CB'(line_reg[REG_ANCHOR_Y] + line_reg[REG_DIR_Y] * t
					+ $urandom_range(0, 6) - 3);
				pz = CB'(line_reg[REG_ANCHOR_Z] + line_reg[REG_DIR_Z] * t
					+ $urandom_range(0, 6) - 3);
			end else begin
				px = CB'($urandom);
				py = CB'($urandom);
				pz = CB'($urandom);
			end
			send_point(px, py, pz);
		end
		s_tvalid <= 1'b0;
	endtask

	// Sink: stall in random bursts, each followed by ready before the next stall
	always @(negedge clk) begin
		if (quiet_tail) begin
			m_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (m_tready && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left <= int'($urandom_range(0, 2));
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each accepted transaction with the oldest expectation
	always @(posedge clk) begin
		dist_result_t want;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_dist.size() == 0) begin
				$display("%0t: unexpected result distance=%0d degenerate=%0d",
					$time, m_tdata[24:0], m_tuser);
				errors++;
			end else begin
				want = pending_dist.pop_front();
				if (m_tdata[24:0] !== want.distance || m_tdata[OUT_DATA_W-1:25] !== '0) begin
					$display("%0t: distance expected %0d actual %0d", $time,
						want.distance, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== want.degenerate) begin
					$display("%0t: degenerate expected %0d actual %0d", $time,
						want.degenerate, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("point_to_line_distance_3d_core_tb: errors");
			$finish;
		end
	end

	// Directed points against the line along x through the origin, direction (1,0,0):
	// distance is sqrt(y^2+z^2), so a few rows are read off directly.
	point_row_t directed [N_DIRECTED];

	initial begin
		dist_result_t want;
		int unsigned idx;
		for (int i = 0; i < 6; i++)
			line_reg[i] = '0;
		directed[0]  = '{16'h8000, 16'd0,    16'd0,    1'b1, '{25'd0, 1'b0}};
		directed[1]  = '{16'h7fff, 16'd3,    16'd4,    1'b1, '{25'd1280, 1'b0}};
		directed[2]  = '{16'd0,    16'd1,    16'd0,    1'b1, '{25'd256, 1'b0}};
		directed[3]  = '{16'd5,    16'hffff, 16'd0,    1'b1, '{25'd256, 1'b0}};
		directed[4]  = '{16'd0,    16'd1,    16'd1,    1'b1, '{25'd362, 1'b0}};
		directed[5]  = '{16'd0,    16'h8000, 16'd0,    1'b1, '{25'd8388608, 1'b0}};
		directed[6]  = '{16'd0,    16'h7fff, 16'h8000, 1'b0, '{25'd0, 1'b0}};
		directed[7]  = '{16'hffff, 16'hffff, 16'hffff, 1'b0, '{25'd0, 1'b0}};
		directed[8]  = '{16'h8000, 16'h8000, 16'h8000, 1'b0, '{25'd0, 1'b0}};
		directed[9]  = '{16'h7fff, 16'h7fff, 16'h7fff, 1'b0, '{25'd0, 1'b0}};
		directed[10] = '{16'h1234, 16'hedcb, 16'h5555, 1'b0, '{25'd0, 1'b0}};
		directed[11] = '{16'haaaa, 16'h0f0f, 16'hf0f0, 1'b0, '{25'd0, 1'b0}};

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// After reset the direction is zero: every point is degenerate
		for (int i = 0; i < 3; i++) begin
			send_point(directed[i].qx, directed[i].qy, directed[i].qz);
			want = pending_dist[$];
			if (want !== dist_result_t'{25'd0, 1'b1}) begin
				$display("%0t: predictor after reset expected 0/1 actual %0d/%0d",
					$time, want.distance, want.degenerate);
				errors++;
			end
		end
		s_tvalid <= 1'b0;
		drain_results();

		write_line(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0);
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_point(directed[i].qx, directed[i].qy, directed[i].qz);
			if (directed[i].has_expect)
				pending_dist[$] = directed[i].known;
		end
		s_tvalid <= 1'b0;
		drain_results();

		// Extreme line: far anchor, largest direction; indexes above five are dropped
		write_line(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'(3'd6);
		cfg_wdata <= 16'h1111;
		@(negedge clk);
		cfg_index <= CFG_IDX_W'(3'd7);
		@(negedge clk);
		cfg_we <= 1'b0;
		send_random(12, 1'b0);
		drain_results();

		// Random lines, each with a mix of near and far points
		for (int phase = 0; phase < 10; phase++) begin
			idx = $urandom_range(0, 3);
			if (idx == 0)
				write_line(CB'($urandom), CB'($urandom), CB'($urandom),
					CB'($urandom_range(0, 7) - 3), CB'($urandom_range(0, 7) - 3),
					CB'($urandom_range(0, 7) - 3));
			else
				write_line(CB'($urandom), CB'($urandom), CB'($urandom),
					CB'($urandom), CB'($urandom), CB'($urandom));
			if (phase == 9)
				quiet_tail = 1'b1;
			send_random(RANDOM_POINTS / 20, 1'b1);
			send_random(RANDOM_POINTS / 20, 1'b0);
			drain_results();
		end

		// Degenerate line again, set by hand
		write_line(CB'($urandom), CB'($urandom), CB'($urandom), 16'd0, 16'd0, 16'd0);
		send_random(20, 1'b0);
		drain_results();

		if (errors == 0)
			$display("point_to_line_distance_3d_core_tb: clean");
		else
			$display("point_to_line_distance_3d_core_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
